// ===== src/ssdi_pkg.sv =====
// Shared types, constants and fixed-point helpers for the stick/slip double integrator.
// No dependencies; compiled first.
`default_nettype none

package ssdi_pkg;

    localparam int VALUE_W     = 32;
    localparam int COEF_U_W    = VALUE_W - 1;
    localparam int OPCODE_W    = 2;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int FRAC_W      = 16;
    localparam int DECAY_FRAC_W = 30;
    localparam int MUL_A_W     = VALUE_W;
    localparam int MUL_B_W     = VALUE_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int RND16_W     = PROD_W - FRAC_W;
    localparam int RND30_W     = PROD_W - DECAY_FRAC_W;
    localparam int SUM_W       = RND16_W + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'd1 << (VALUE_W - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [VALUE_W-1:0] DECAY_RESET = VALUE_W'(64'd1 << DECAY_FRAC_W);

    typedef enum logic [OPCODE_W-1:0] {
        OP_INTEGRATE  = 2'd0,
        OP_INTEG_SAVE = 2'd1,
        OP_REDO       = 2'd2,
        OP_LOAD       = 2'd3
    } t_opcode;

    typedef enum logic [MODE_W-1:0] {
        MODE_STILL = 2'd0,
        MODE_POS   = 2'd1,
        MODE_NEG   = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VELOCITY_DECAY   = 3'd0,
        CFG_INPUT_GAIN       = 3'd1,
        CFG_HALF_STEP        = 3'd2,
        CFG_STOP_GAIN        = 3'd3,
        CFG_STATIC_THRESHOLD = 3'd4,
        CFG_KINETIC_FRICTION = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_STOP,
        ST_MUL_DECAY,
        ST_MUL_GAIN,
        ST_SUM_VEL,
        ST_MUL_HALF,
        ST_SUM_POS,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        MS_STOP,
        MS_DECAY,
        MS_GAIN,
        MS_HALF
    } t_mul_sel;

    typedef enum logic [2:0] {
        CM_NONE,
        CM_MODE,
        CM_STOP,
        CM_ADV,
        CM_LOAD
    } t_commit;

    typedef struct packed {
        logic     capture;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     ues_en;
        logic     acc_en;
        logic     nv_en;
        t_commit  commit;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        t_opcode op;
        logic    moving;
        logic    stop;
        logic    out_free;
    } t_status;

    typedef struct packed {
        t_opcode                    opcode;
        logic signed [VALUE_W-1:0]  accel;
        logic signed [VALUE_W-1:0]  load_position;
        logic signed [VALUE_W-1:0]  load_velocity;
        logic signed [VALUE_W-1:0]  load_prev_accel;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  velocity;
        logic signed [VALUE_W-1:0]  position;
        t_mode                      motion_mode;
        logic                       saturated;
    } t_out_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      ovf;
    } t_sat_res;

    function automatic t_sat_res sat_value(input logic signed [SUM_W-1:0] x);
        t_sat_res res;
        res.ovf = 1'b0;
        if (x > SAT_HI) begin
            res.value = SAT_HI[VALUE_W-1:0];
            res.ovf   = 1'b1;
        end else if (x < SAT_LO) begin
            res.value = SAT_LO[VALUE_W-1:0];
            res.ovf   = 1'b1;
        end else begin
            res.value = x[VALUE_W-1:0];
        end
        return res;
    endfunction

    // round half away from zero: bias by half, less one when negative, then shift
    function automatic logic signed [RND16_W-1:0] round16(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] t;
        t = p + {{(PROD_W-FRAC_W){1'b0}}, ~p[PROD_W-1], {(FRAC_W-1){p[PROD_W-1]}}};
        return t[PROD_W-1:FRAC_W];
    endfunction

    function automatic logic signed [RND30_W-1:0] round30(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] t;
        t = p + {{(PROD_W-DECAY_FRAC_W){1'b0}}, ~p[PROD_W-1],
                 {(DECAY_FRAC_W-1){p[PROD_W-1]}}};
        return t[PROD_W-1:DECAY_FRAC_W];
    endfunction

endpackage

`default_nettype wire

// ===== src/ssdi_if.sv =====
// Valid/ready channel interfaces: input word, result word, configuration write.
// Depends on ssdi_pkg.
`default_nettype none

interface ssdi_in_if import ssdi_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OPCODE_W-1:0]       opcode;
    logic signed [VALUE_W-1:0] accel;
    logic signed [VALUE_W-1:0] load_position;
    logic signed [VALUE_W-1:0] load_velocity;
    logic signed [VALUE_W-1:0] load_prev_accel;

    modport source (output valid, opcode, accel, load_position, load_velocity,
                    load_prev_accel, input ready);
    modport sink   (input valid, opcode, accel, load_position, load_velocity,
                    load_prev_accel, output ready);
endinterface

interface ssdi_out_if import ssdi_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] velocity;
    logic signed [VALUE_W-1:0] position;
    logic [MODE_W-1:0]         motion_mode;
    logic                      saturated;

    modport source (output valid, velocity, position, motion_mode, saturated, input ready);
    modport sink   (input valid, velocity, position, motion_mode, saturated, output ready);
endinterface

interface ssdi_cfg_if import ssdi_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VALUE_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/ssdi_ctrl.sv =====
// Step sequencer: walks one word through the shared multiplier and commits the result.
// Depends on ssdi_pkg; drives the datapath through t_cmd, reads t_status.
`default_nettype none

module ssdi_ctrl import ssdi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_MUL_STOP;
                end
            end
            ST_MUL_STOP: begin
                if (i_status.op == OP_LOAD) begin
                    n_state = ST_LOAD;
                end else if (i_status.op == OP_REDO) begin
                    n_state = ST_MUL_DECAY;
                end else begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = MS_STOP;
                    n_state = ST_MUL_DECAY;
                end
            end
            ST_LOAD: begin
                o_cmd.commit = CM_LOAD;
                n_state = ST_EMIT;
            end
            ST_MUL_DECAY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_DECAY;
                o_cmd.ues_en  = 1'b1;
                n_state = ST_MUL_GAIN;
            end
            ST_MUL_GAIN: begin
                if (i_status.op != OP_REDO && !i_status.moving) begin
                    o_cmd.commit = CM_MODE;
                    n_state = ST_EMIT;
                end else if (i_status.op != OP_REDO && i_status.stop) begin
                    o_cmd.commit = CM_STOP;
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = MS_GAIN;
                    o_cmd.acc_en  = 1'b1;
                    n_state = ST_SUM_VEL;
                end
            end
            ST_SUM_VEL: begin
                o_cmd.nv_en = 1'b1;
                n_state = ST_MUL_HALF;
            end
            ST_MUL_HALF: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_HALF;
                n_state = ST_SUM_POS;
            end
            ST_SUM_POS: begin
                o_cmd.commit = CM_ADV;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken twice without finishing a step");
    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("result emitted over an untaken word");
    a_one_commit_per_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit != CM_NONE) |=> (o_cmd.commit == CM_NONE))
        else $error("state committed in two consecutive cycles");
`endif

endmodule

`default_nettype wire

// ===== src/ssdi_dpath.sv =====
// Datapath: configuration registers, integrator state, backup, one shared multiplier,
// rounding and saturating adders, result register. Depends on ssdi_pkg and ssdi_cfg_if.
`default_nettype none

module ssdi_dpath import ssdi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    input  t_in_word   i_in_word,
    ssdi_cfg_if.sink   i_cfg,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_out_word  o_out_word
);

    // configuration
    logic signed [VALUE_W-1:0] r_decay;
    logic signed [VALUE_W-1:0] r_gain;
    logic [COEF_U_W-1:0]       r_half;
    logic signed [VALUE_W-1:0] r_stop_gain;
    logic [COEF_U_W-1:0]       r_static;
    logic [COEF_U_W-1:0]       r_kinetic;

    // architectural state
    logic signed [VALUE_W-1:0] r_vel;
    logic signed [VALUE_W-1:0] r_pos;
    logic signed [VALUE_W-1:0] r_prev;
    t_mode                     r_mode;
    logic signed [VALUE_W-1:0] r_vel_bk;
    logic signed [VALUE_W-1:0] r_pos_bk;
    logic signed [VALUE_W-1:0] r_prev_bk;

    // step working registers
    t_in_word                  r_in;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_ues;
    logic signed [RND30_W-1:0] r_acc;
    logic signed [VALUE_W-1:0] r_nv;
    logic                      r_flag;
    logic                      r_out_valid;
    t_out_word                 r_out;

    logic signed [VALUE_W-1:0] v0;
    logic signed [VALUE_W-1:0] p0;
    logic signed [VALUE_W-1:0] u0;
    logic signed [VALUE_W:0]   accel_x;
    logic signed [VALUE_W:0]   kinetic_x;
    logic signed [VALUE_W:0]   static_x;
    logic signed [VALUE_W:0]   ue_raw;
    t_sat_res                  ue_sat;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [RND16_W-1:0] rnd16;
    logic signed [SUM_W-1:0]   n_ues;
    t_sat_res                  nv_sat;
    t_sat_res                  pos_sat;
    t_mode                     n_break_mode;
    logic                      stop;

    assign i_cfg.ready = 1'b1;

    assign v0 = (r_in.opcode == OP_REDO) ? r_vel_bk  : r_vel;
    assign p0 = (r_in.opcode == OP_REDO) ? r_pos_bk  : r_pos;
    assign u0 = (r_in.opcode == OP_REDO) ? r_prev_bk : r_prev;

    assign accel_x   = (VALUE_W+1)'(r_in.accel);
    assign kinetic_x = $signed({2'b00, r_kinetic});
    assign static_x  = $signed({2'b00, r_static});

    always_comb begin
        if (r_in.opcode == OP_REDO) begin
            ue_raw = accel_x;
        end else if (r_mode == MODE_NEG) begin
            ue_raw = accel_x + kinetic_x;
        end else begin
            ue_raw = accel_x - kinetic_x;
        end
    end

    assign ue_sat = sat_value(SUM_W'(ue_raw));

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_STOP: begin
                mul_a = r_stop_gain;
                mul_b = MUL_B_W'(r_vel);
            end
            MS_DECAY: begin
                mul_a = r_decay;
                mul_b = MUL_B_W'(v0);
            end
            MS_GAIN: begin
                mul_a = r_gain;
                mul_b = MUL_B_W'(ue_sat.value) + MUL_B_W'(u0);
            end
            MS_HALF: begin
                mul_a = $signed({1'b0, r_half});
                mul_b = MUL_B_W'(r_nv) + MUL_B_W'(v0);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign rnd16   = round16(r_prod);
    assign n_ues   = -SUM_W'(rnd16) - SUM_W'(r_prev);
    assign nv_sat  = sat_value(SUM_W'(r_acc) + SUM_W'(rnd16));
    assign pos_sat = sat_value(SUM_W'(p0) + SUM_W'(rnd16));

    always_comb begin
        unique case (r_mode)
            MODE_POS: stop = r_ues > SUM_W'(ue_raw);
            MODE_NEG: stop = r_ues < SUM_W'(ue_raw);
            default:  stop = 1'b0;
        endcase
    end

    always_comb begin
        unique case (r_mode)
            MODE_STILL: begin
                if (accel_x >= static_x) begin
                    n_break_mode = MODE_POS;
                end else if (accel_x <= -static_x) begin
                    n_break_mode = MODE_NEG;
                end else begin
                    n_break_mode = MODE_STILL;
                end
            end
            MODE_POS, MODE_NEG: n_break_mode = r_mode;
            default:            n_break_mode = MODE_STILL;
        endcase
    end

    assign o_status.op       = r_in.opcode;
    assign o_status.moving   = (r_mode == MODE_POS) || (r_mode == MODE_NEG);
    assign o_status.stop     = stop;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // configuration, state and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay     <= DECAY_RESET;
            r_gain      <= '0;
            r_half      <= '0;
            r_stop_gain <= '0;
            r_static    <= '0;
            r_kinetic   <= '0;
            r_vel       <= '0;
            r_pos       <= '0;
            r_prev      <= '0;
            r_mode      <= MODE_STILL;
            r_vel_bk    <= '0;
            r_pos_bk    <= '0;
            r_prev_bk   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_VELOCITY_DECAY:   r_decay     <= $signed(i_cfg.data);
                    CFG_INPUT_GAIN:       r_gain      <= $signed(i_cfg.data);
                    CFG_HALF_STEP:        r_half      <= i_cfg.data[COEF_U_W-1:0];
                    CFG_STOP_GAIN:        r_stop_gain <= $signed(i_cfg.data);
                    CFG_STATIC_THRESHOLD: r_static    <= i_cfg.data[COEF_U_W-1:0];
                    CFG_KINETIC_FRICTION: r_kinetic   <= i_cfg.data[COEF_U_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.capture && i_in_word.opcode == OP_INTEG_SAVE) begin
                r_vel_bk  <= r_vel;
                r_pos_bk  <= r_pos;
                r_prev_bk <= r_prev;
            end
            case (i_cmd.commit)
                CM_MODE: r_mode <= n_break_mode;
                CM_STOP: begin
                    r_vel  <= '0;
                    r_mode <= MODE_STILL;
                end
                CM_ADV: begin
                    r_vel  <= r_nv;
                    r_pos  <= pos_sat.value;
                    r_prev <= ue_sat.value;
                end
                CM_LOAD: begin
                    r_vel  <= r_in.load_velocity;
                    r_pos  <= r_in.load_position;
                    r_prev <= r_in.load_prev_accel;
                end
                default: ;
            endcase
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in   <= i_in_word;
            r_flag <= 1'b0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.ues_en) begin
            r_ues <= n_ues;
        end
        if (i_cmd.acc_en) begin
            r_acc <= round30(r_prod);
        end
        if (i_cmd.nv_en) begin
            r_nv   <= nv_sat.value;
            r_flag <= r_flag | nv_sat.ovf | ue_sat.ovf;
        end
        if (i_cmd.commit == CM_ADV) begin
            r_flag <= r_flag | pos_sat.ovf;
        end
        if (i_cmd.emit) begin
            r_out.velocity    <= r_vel;
            r_out.position    <= r_pos;
            r_out.motion_mode <= r_mode;
            r_out.saturated   <= r_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_stop_zeroes_velocity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit == CM_STOP) |=> (r_vel == '0 && r_mode == MODE_STILL))
        else $error("stop did not clear velocity and mode");
    a_advance_keeps_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit == CM_ADV) |=> $stable(r_mode))
        else $error("integration step changed the motion mode");
`endif

endmodule

`default_nettype wire

// ===== src/stick_slip_double_integrator.sv =====
// Stick/slip double integrator top level: sequencer plus datapath with one shared multiplier.
// An integrating word runs the stop, decay, gain and half-step multiplies; at standstill or
// on a stop it ends after decay, and a state load skips them. Words are taken only in idle.
// Reset (synchronous, active low) zeroes the state and backup, mode standing still,
// velocity_decay to one, other coefficients to zero. Depends on ssdi_pkg, ssdi_if.
`default_nettype none

module stick_slip_double_integrator import ssdi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssdi_in_if.sink     i_in,
    ssdi_out_if.source  o_out,
    ssdi_cfg_if.sink    i_cfg
);

    t_cmd      w_cmd;
    t_status   w_status;
    t_in_word  w_in_word;
    t_out_word w_out_word;
    logic      w_in_ready;
    logic      w_out_valid;

    assign w_in_word.opcode          = t_opcode'(i_in.opcode);
    assign w_in_word.accel           = i_in.accel;
    assign w_in_word.load_position   = i_in.load_position;
    assign w_in_word.load_velocity   = i_in.load_velocity;
    assign w_in_word.load_prev_accel = i_in.load_prev_accel;
    assign i_in.ready                = w_in_ready;

    assign o_out.valid       = w_out_valid;
    assign o_out.velocity    = w_out_word.velocity;
    assign o_out.position    = w_out_word.position;
    assign o_out.motion_mode = w_out_word.motion_mode;
    assign o_out.saturated   = w_out_word.saturated;

    ssdi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ssdi_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_word   (w_in_word),
        .i_cfg       (i_cfg),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_out_word  (w_out_word)
    );

endmodule

`default_nettype wire
